### rtl/tcpopt_pkg.sv
// tcpopt_pkg: shared types and constants of the tcp option parser
// transaction payload structs, option kind codes and exact option lengths
// no dependencies
package tcpopt_pkg;

  // option region limit in bytes (tcp allows at most 40 option bytes)
  localparam int unsigned MAX_OPT_BYTES = 40;

  // fixed tcp header length ahead of the option region
  localparam int unsigned HDR_BASE = 20;

  // mss value when no mss option is present
  localparam logic [15:0] MSS_DEFAULT = 16'd536;

  // option kind codes
  localparam logic [7:0] KIND_EOL      = 8'd0;
  localparam logic [7:0] KIND_NOP      = 8'd1;
  localparam logic [7:0] KIND_MSS      = 8'd2;
  localparam logic [7:0] KIND_WSCALE   = 8'd3;
  localparam logic [7:0] KIND_SACK_OK  = 8'd4;
  localparam logic [7:0] KIND_STAMP    = 8'd8;

  // option lengths that are accepted for the known kinds
  localparam logic [7:0] LEN_MSS       = 8'd4;
  localparam logic [7:0] LEN_WSCALE    = 8'd3;
  localparam logic [7:0] LEN_SACK_OK   = 8'd2;
  localparam logic [7:0] LEN_STAMP     = 8'd10;

  // smallest legal option length (kind and length bytes)
  localparam logic [7:0] LEN_MIN       = 8'd2;

  // one option region byte with its header framing
  typedef struct packed {
    logic [7:0] opt_byte;
    logic [5:0] region_len;
    logic       first_byte;
    logic       last_byte;
  } opt_item_t;

  // per-header option summary
  typedef struct packed {
    logic        options_ok;
    logic [15:0] max_segment;
    logic [5:0]  mss_position;
    logic [7:0]  window_shift;
    logic        sack_allowed;
    logic        stamp_seen;
    logic [31:0] stamp_value;
    logic [31:0] stamp_echo;
  } opt_result_t;

endpackage

### rtl/tcp_option_parser.sv
// tcp_option_parser: streaming tcp option walker, one option byte per transaction
// one summary transaction per header, produced on the header's last byte
// depends on tcpopt_pkg
//
// usage:
//   opt channel (opt_valid/opt_ready/opt) carries the option region of a tcp
//   header one byte per transaction, with region_len (data offset * 4 - 20)
//   repeated on every byte, first_byte on the first and last_byte on the last.
//   an empty region is sent as one dummy transaction with both flags set.
//   res channel (res_valid/res_ready/res) carries one summary per header:
//   list status, mss and its header offset, window scale, sack-permitted and
//   timestamp value/echo.
// timing:
//   one transaction per cycle unless a last byte waits on a stalled result; each
//   byte goes from the input register through the option walk into the parser
//   state. the summary is loaded from the input register into the result
//   register when the last byte moves on, and res is valid from there.
// reset:
//   rst (synchronous) empties both registers and clears the header state.
// stall:
//   a stalled result holds in the result register; bytes that are not the
//   last of a header keep flowing past it, and only a last byte waits for the
//   result register to free up, which then holds opt_ready low.
module tcp_option_parser
  import tcpopt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        opt_valid,
  output logic        opt_ready,
  input  opt_item_t   opt,
  output logic        res_valid,
  input  logic        res_ready,
  output opt_result_t res
);

  // walk phase: expecting kind, length, skipping value, or taking value
  typedef enum logic [1:0] {
    PH_KIND,
    PH_LEN,
    PH_SKIP,
    PH_TAKE
  } phase_t;

  // per-header parser state
  typedef struct packed {
    logic [5:0]  byte_pos;
    phase_t      phase;
    logic [7:0]  cur_kind;
    logic [5:0]  skip_left;
    logic        halted;
    logic        valid_flag;
    logic [15:0] mss_acc;
    logic [5:0]  mss_at;
    logic [7:0]  shift_acc;
    logic        sack_flag;
    logic        stamp_flag;
    logic [31:0] stamp_acc;
    logic [31:0] echo_acc;
  } hdr_state_t;

  localparam hdr_state_t HDR_CLEAR = '{
    byte_pos:   '0,
    phase:      PH_KIND,
    cur_kind:   '0,
    skip_left:  '0,
    halted:     1'b0,
    valid_flag: 1'b0,
    mss_acc:    MSS_DEFAULT,
    mss_at:     '0,
    shift_acc:  '0,
    sack_flag:  1'b0,
    stamp_flag: 1'b0,
    stamp_acc:  '0,
    echo_acc:   '0
  };

  localparam logic [5:0] LEN_LIMIT = 6'(MAX_OPT_BYTES);
  localparam logic [5:0] POS_MAX   = '1;
  // mss header offset is taken on its last value byte, which sits 3 past the kind
  localparam logic [5:0] MSS_AT_ADJ = 6'(HDR_BASE - 32'(LEN_MSS) + 1);

  // input register
  logic       in_vld;
  opt_item_t  in_q;

  // parser state
  hdr_state_t st;
  hdr_state_t st_next;

  // summary computed from the byte in the input register
  opt_result_t result;

  logic advance;

  // the input stage moves on unless it holds a last byte and the result is stuck
  assign advance   = in_vld && (!in_q.last_byte || !res_valid || res_ready);
  assign opt_ready = !in_vld || advance;

  // option walk for one byte
  always_comb begin
    hdr_state_t w;
    logic [5:0] len;
    logic [5:0] pos;
    logic [7:0] b;
    logic [6:0] rem;
    logic [7:0] olen;
    logic       exact;

    w    = in_q.first_byte ? HDR_CLEAR : st;
    len  = (in_q.region_len > LEN_LIMIT) ? LEN_LIMIT : in_q.region_len;
    pos  = w.byte_pos;
    b    = in_q.opt_byte;
    // bytes left in the region counted from the kind byte
    rem  = {1'b0, len} - {1'b0, pos} + 7'd1;
    olen = (b < {1'b0, rem}) ? b : {1'b0, rem};
    exact = ((w.cur_kind == KIND_MSS)     && (olen == LEN_MSS))     ||
            ((w.cur_kind == KIND_WSCALE)  && (olen == LEN_WSCALE))  ||
            ((w.cur_kind == KIND_SACK_OK) && (olen == LEN_SACK_OK)) ||
            ((w.cur_kind == KIND_STAMP)   && (olen == LEN_STAMP));

    if (!w.halted && (pos < len)) begin
      case (w.phase)
        PH_KIND: begin
          if (b == KIND_EOL) begin
            w.valid_flag = 1'b1;
            w.halted     = 1'b1;
          end else if (b != KIND_NOP) begin
            w.cur_kind = b;
            // no room left for a length byte
            if (({1'b0, pos} + 7'd1) >= {1'b0, len}) begin
              w.halted = 1'b1;
            end else begin
              w.phase = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (olen < LEN_MIN) begin
            w.halted = 1'b1;
          end else begin
            w.skip_left = 6'(olen - LEN_MIN);
            if (exact && (w.cur_kind == KIND_SACK_OK)) begin
              w.sack_flag = 1'b1;
            end
            if (olen == LEN_MIN) begin
              w.phase = PH_KIND;
            end else begin
              w.phase = exact ? PH_TAKE : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          w.skip_left = w.skip_left - 6'd1;
          if (w.skip_left == '0) begin
            w.phase = PH_KIND;
          end
        end
        PH_TAKE: begin
          if (w.cur_kind == KIND_MSS) begin
            w.mss_acc = {w.mss_acc[7:0], b};
          end else if (w.cur_kind == KIND_WSCALE) begin
            w.shift_acc = b;
          end else begin
            // value and echo shift through as one 64-bit big-endian word
            w.stamp_acc = {w.stamp_acc[23:0], w.echo_acc[31:24]};
            w.echo_acc  = {w.echo_acc[23:0], b};
          end
          w.skip_left = w.skip_left - 6'd1;
          if (w.skip_left == '0) begin
            if (w.cur_kind == KIND_MSS) begin
              w.mss_at = pos + MSS_AT_ADJ;
            end else if (w.cur_kind == KIND_STAMP) begin
              w.stamp_flag = 1'b1;
            end
            w.phase = PH_KIND;
          end
        end
        default: begin
          w.phase = PH_KIND;
        end
      endcase
    end

    if (pos != POS_MAX) begin
      w.byte_pos = pos + 6'd1;
    end

    // clean end: end-of-list seen, or stopped at an option boundary
    result.options_ok   = w.halted ? w.valid_flag : (w.phase == PH_KIND);
    result.max_segment  = w.mss_acc;
    result.mss_position = w.mss_at;
    result.window_shift = w.shift_acc;
    result.sack_allowed = w.sack_flag;
    result.stamp_seen   = w.stamp_flag;
    result.stamp_value  = w.stamp_acc;
    result.stamp_echo   = w.echo_acc;

    // a delivered summary starts the next header from scratch
    st_next = in_q.last_byte ? HDR_CLEAR : w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      res_valid <= 1'b0;
      st        <= HDR_CLEAR;
    end else begin
      if (opt_ready) begin
        in_vld <= opt_valid;
      end
      if (opt_valid && opt_ready) begin
        in_q <= opt;
      end
      if (advance) begin
        st <= st_next;
      end
      // result register: load on a last byte, else free on a taken transaction
      res_valid <= (advance && in_q.last_byte) || (res_valid && !res_ready);
      if (advance && in_q.last_byte) begin
        res <= result;
      end
    end
  end

endmodule

### rtl/tcpopt_checker.sv
// tcpopt_checker: port-level checks of the tcp option parser
// bound to tcp_option_parser; depends on tcpopt_pkg
module tcpopt_checker
  import tcpopt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        opt_valid,
  input logic        opt_ready,
  input opt_item_t   opt,
  input logic        res_valid,
  input logic        res_ready,
  input opt_result_t res
);

  // a stalled summary stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("summary withdrawn while stalled");

  // a stalled summary keeps its contents
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res))
    else $error("summary changed while stalled");

  // a header's accepted last byte yields a summary in the result register once it has passed the input register
  a_last_gives_res: assert property (@(posedge clk) disable iff (rst)
    opt_valid && opt_ready && opt.last_byte |=> ##1 res_valid)
    else $error("no summary after last byte");

  // an mss offset, when present, lies inside the option region of the header
  a_mss_pos_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.mss_position != 6'd0) |->
      (res.mss_position >= 6'd20) && (res.mss_position <= 6'd56))
    else $error("mss offset outside option region");

endmodule

bind tcp_option_parser tcpopt_checker u_tcpopt_checker (
  .clk       (clk),
  .rst       (rst),
  .opt_valid (opt_valid),
  .opt_ready (opt_ready),
  .opt       (opt),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

### bench/tb.sv
// tb: self-checking bench for tcp_option_parser, streams option regions byte by byte
// a scoreboard class predicts each header summary and checks the result channel
// depends on tcpopt_pkg and rtl/tcp_option_parser.sv
import tcpopt_pkg::*;

class option_scoreboard;
  typedef enum logic [1:0] {WALK_KIND, WALK_LEN, WALK_SKIP, WALK_TAKE} walk_phase_t;

  localparam int unsigned POS_SAT = 63;

  int unsigned pos;
  walk_phase_t phase;
  logic [7:0]  kind;
  int unsigned skip_left;
  bit          halted;
  bit          list_ok;
  bit          sack_f;
  bit          stamp_f;
  logic [15:0] mss;
  logic [5:0]  mss_at;
  logic [7:0]  wshift;
  logic [31:0] tsval;
  logic [31:0] tsecr;

  opt_result_t summaries[$];
  int unsigned errors;

  function new();
    errors = 0;
    clear();
  endfunction

  function void clear();
    pos = 0;
    phase = WALK_KIND;
    kind = '0;
    skip_left = 0;
    halted = 0;
    list_ok = 0;
    sack_f = 0;
    stamp_f = 0;
    mss = MSS_DEFAULT;
    mss_at = '0;
    wshift = '0;
    tsval = '0;
    tsecr = '0;
  endfunction

  // value byte of an option taken at its exact length
  function void take(logic [7:0] b, int unsigned p);
    if (kind == KIND_MSS) begin
      mss = {mss[7:0], b};
    end else if (kind == KIND_WSCALE) begin
      wshift = b;
    end else begin
      tsval = {tsval[23:0], tsecr[31:24]};
      tsecr = {tsecr[23:0], b};
    end
    skip_left--;
    if (skip_left == 0) begin
      if (kind == KIND_MSS) begin
        mss_at = 6'(HDR_BASE + p + 1 - LEN_MSS);
      end else if (kind == KIND_STAMP) begin
        stamp_f = 1;
      end
      phase = WALK_KIND;
    end
  endfunction

  function void walk(logic [7:0] b, int unsigned p, int unsigned len);
    int unsigned rem;
    int unsigned olen;
    bit exact;
    case (phase)
      WALK_KIND: begin
        if (b == KIND_EOL) begin
          list_ok = 1;
          halted = 1;
        end else if (b != KIND_NOP) begin
          kind = b;
          // kind byte at the region end has no length byte
          if (p + 1 >= len) halted = 1;
          else phase = WALK_LEN;
        end
      end
      WALK_LEN: begin
        rem = len - (p - 1);
        olen = (b < rem) ? b : rem;
        if (olen < LEN_MIN) begin
          halted = 1;
        end else begin
          skip_left = olen - LEN_MIN;
          exact = (kind == KIND_MSS && olen == LEN_MSS) ||
                  (kind == KIND_WSCALE && olen == LEN_WSCALE) ||
                  (kind == KIND_SACK_OK && olen == LEN_SACK_OK) ||
                  (kind == KIND_STAMP && olen == LEN_STAMP);
          if (exact && kind == KIND_SACK_OK) sack_f = 1;
          if (skip_left == 0) phase = WALK_KIND;
          else if (exact) phase = WALK_TAKE;
          else phase = WALK_SKIP;
        end
      end
      WALK_SKIP: begin
        skip_left--;
        if (skip_left == 0) phase = WALK_KIND;
      end
      default: take(b, p);
    endcase
  endfunction

  // accepted input transaction
  function void note_item(opt_item_t it);
    int unsigned len;
    opt_result_t s;
    len = (it.region_len > MAX_OPT_BYTES) ? MAX_OPT_BYTES : it.region_len;
    if (it.first_byte) clear();
    if (!halted && pos < len) walk(it.opt_byte, pos, len);
    if (pos < POS_SAT) pos++;
    if (it.last_byte) begin
      s.options_ok   = halted ? list_ok : (phase == WALK_KIND);
      s.max_segment  = mss;
      s.mss_position = mss_at;
      s.window_shift = wshift;
      s.sack_allowed = sack_f;
      s.stamp_seen   = stamp_f;
      s.stamp_value  = tsval;
      s.stamp_echo   = tsecr;
      summaries.push_back(s);
      clear();
    end
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // accepted result transaction
  task check_summary(opt_result_t got);
    opt_result_t want;
    if (summaries.size() == 0) begin
      report("summary with no header pending");
      return;
    end
    want = summaries.pop_front();
    check_field("options_ok", 32'(got.options_ok), 32'(want.options_ok));
    check_field("max_segment", 32'(got.max_segment), 32'(want.max_segment));
    check_field("mss_position", 32'(got.mss_position), 32'(want.mss_position));
    check_field("window_shift", 32'(got.window_shift), 32'(want.window_shift));
    check_field("sack_allowed", 32'(got.sack_allowed), 32'(want.sack_allowed));
    check_field("stamp_seen", 32'(got.stamp_seen), 32'(want.stamp_seen));
    check_field("stamp_value", got.stamp_value, want.stamp_value);
    check_field("stamp_echo", got.stamp_echo, want.stamp_echo);
  endtask
endclass

module tb;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 400;

  logic        clk;
  logic        rst;
  logic        opt_valid;
  logic        opt_ready;
  opt_item_t   opt;
  logic        res_valid;
  logic        res_ready;
  opt_result_t res;

  option_scoreboard sb;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  logic [7:0]  hdr_bytes[$];

  tcp_option_parser dut (
    .clk       (clk),
    .rst       (rst),
    .opt_valid (opt_valid),
    .opt_ready (opt_ready),
    .opt       (opt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ready <= !rst && ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_summary(res);
    if (!rst && opt_valid && opt_ready) sb.note_item(opt);
    if ((opt_valid && opt_ready) || (res_valid && res_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input opt_item_t it);
    while ($urandom_range(99) < send_idle) begin
      opt_valid <= 1'b0;
      @(negedge clk);
    end
    opt_valid <= 1'b1;
    opt <= it;
    do @(posedge clk); while (!opt_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // count 0 sends the dummy transaction of an empty region
  task automatic send_header(input logic [5:0] len, input int unsigned count, input bit noisy);
    opt_item_t it;
    int unsigned i;
    it.region_len = len;
    if (count == 0) begin
      it.opt_byte = 8'($urandom);
      it.first_byte = 1'b1;
      it.last_byte = 1'b1;
      send_item(it);
    end else begin
      for (i = 0; i < count; i++) begin
        it.opt_byte = hdr_bytes[i];
        it.first_byte = noisy ? 1'($urandom) : (i == 0);
        it.last_byte = noisy ? 1'($urandom) : (i == count - 1);
        send_item(it);
      end
    end
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) hdr_bytes.push_back(8'($urandom));
  endtask

  // mostly well-formed option lists, with wrong lengths and junk mixed in
  task automatic build_options(input int unsigned target);
    int unsigned pick;
    int unsigned olen;
    logic [15:0] mss_val;
    logic [7:0]  known;
    hdr_bytes.delete();
    while (hdr_bytes.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        hdr_bytes.push_back(KIND_NOP);
      end else if (pick < 24) begin
        case ($urandom_range(3))
          0: mss_val = 16'h0000;
          1: mss_val = 16'hffff;
          default: mss_val = 16'($urandom);
        endcase
        hdr_bytes.push_back(KIND_MSS);
        hdr_bytes.push_back(LEN_MSS);
        hdr_bytes.push_back(mss_val[15:8]);
        hdr_bytes.push_back(mss_val[7:0]);
      end else if (pick < 36) begin
        hdr_bytes.push_back(KIND_WSCALE);
        hdr_bytes.push_back(LEN_WSCALE);
        push_random(1);
      end else if (pick < 46) begin
        hdr_bytes.push_back(KIND_SACK_OK);
        hdr_bytes.push_back(LEN_SACK_OK);
      end else if (pick < 60) begin
        hdr_bytes.push_back(KIND_STAMP);
        hdr_bytes.push_back(LEN_STAMP);
        push_random(8);
      end else if (pick < 66) begin
        hdr_bytes.push_back(KIND_EOL);
      end else if (pick < 80) begin
        // kind 5 or above at a length that is not taken, skipped
        olen = $urandom_range(2, 8);
        hdr_bytes.push_back(8'($urandom_range(5, 255)));
        hdr_bytes.push_back(8'(olen));
        push_random(olen - 2);
      end else if (pick < 92) begin
        // known kind at an arbitrary length
        case ($urandom_range(3))
          0: known = KIND_MSS;
          1: known = KIND_WSCALE;
          2: known = KIND_SACK_OK;
          default: known = KIND_STAMP;
        endcase
        olen = $urandom_range(2, 12);
        hdr_bytes.push_back(known);
        hdr_bytes.push_back(8'(olen));
        push_random(olen - 2);
      end else begin
        push_random($urandom_range(2, 5));
      end
    end
  endtask

  task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle);
    int unsigned start;
    int unsigned target;
    int unsigned pick;
    int unsigned count;
    int unsigned extra;
    logic [5:0]  len;
    bit          noisy;
    send_idle = s_idle;
    recv_idle = r_idle;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      target = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, MAX_OPT_BYTES);
      build_options(target);
      len = 6'(target);
      count = target;
      noisy = 0;
      if (pick < 10 && target > 0) begin
        // bytes past the region end
        extra = $urandom_range(1, 4);
        while (hdr_bytes.size() < target + extra) push_random(1);
        count = target + extra;
      end else if (pick < 20 && target > 1) begin
        // stream cut short of the region
        count = $urandom_range(1, target - 1);
      end else if (pick < 26) begin
        len = 6'($urandom_range(MAX_OPT_BYTES + 1, 63));
      end else if (pick < 34) begin
        // junk bytes with random framing
        hdr_bytes.delete();
        push_random($urandom_range(1, 12));
        count = hdr_bytes.size();
        len = 6'($urandom_range(63));
        noisy = 1;
      end
      send_header(len, count, noisy);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    opt_valid = 1'b0;
    opt = '0;
    send_idle = 0;
    recv_idle = 0;
    items_sent = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed headers
    send_idle = 11;
    recv_idle = 51;
    hdr_bytes.delete();
    send_header(6'd0, 0, 0);
    hdr_bytes = {KIND_MSS, LEN_MSS, 8'hff, 8'hff};
    send_header(6'd4, 4, 0);
    // nop, window scale, sack-permitted, end of list, then a byte past the region
    hdr_bytes = {KIND_NOP, KIND_WSCALE, LEN_WSCALE, 8'hff, KIND_SACK_OK, LEN_SACK_OK,
                 KIND_EOL, 8'haa};
    send_header(6'd7, 8, 0);
    // timestamp with an oversized region that the stream never fills
    hdr_bytes = {KIND_STAMP, LEN_STAMP, 8'hff, 8'hff, 8'hff, 8'hff,
                 8'hff, 8'hff, 8'hff, 8'hff};
    send_header(6'd63, 10, 0);
    // length below the minimum
    hdr_bytes = {8'd5, 8'd1};
    send_header(6'd2, 2, 0);
    // kind in the last region byte, no room for its length
    hdr_bytes = {KIND_NOP, 8'd6};
    send_header(6'd2, 2, 0);
    // mss length clamped to the region, then skipped
    hdr_bytes = {KIND_MSS, 8'd200, 8'h12};
    send_header(6'd3, 3, 0);

    run_phase(11, 51);
    run_phase(51, 11);
    run_phase(0, 0);

    opt_valid <= 1'b0;
    while (sb.summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
